>>> rtl/modbus_detection_frame_parser_top_assert.svh
// Assertion macros for the checker file of the frame parser.
`ifndef MODBUS_DETECTION_FRAME_PARSER_TOP_ASSERT_SVH
`define MODBUS_DETECTION_FRAME_PARSER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MDFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mdfp_pkg.sv
package mdfp_pkg;

  // Frame layout of one sensor response.
  localparam int unsigned FRAME_LEN    = 25;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned COUNT_OFFSET = 10;
  localparam int unsigned DET_OFFSET   = 11;
  localparam int unsigned DET_BYTES    = 4;
  localparam int unsigned CRC_LO_POS   = 23;

  // The byte counter value seen while the final byte of a full frame arrives.
  localparam logic [CNT_W-1:0] CNT_LAST_BYTE = CNT_W'(FRAME_LEN - 1);
  // Saturated count meaning more than a full frame.
  localparam logic [CNT_W-1:0] CNT_SAT       = CNT_W'(FRAME_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_FRAME_LEN = CNT_W'(FRAME_LEN);
  localparam logic [CNT_W-1:0] CNT_CRC_START = CNT_W'(2);

  localparam logic [7:0]  FUNC_READ_INPUT = 8'h04;
  localparam logic [7:0]  DEV_ADDR_RESET  = 8'd1;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;

  localparam int unsigned MAX_DET_DEFAULT = 3;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_RESP = 2'd1,
    STATUS_BAD_CRC  = 2'd2,
    STATUS_TOO_MANY = 2'd3
  } status_e;

  typedef struct packed {
    logic [15:0] distance_cm;
    logic [15:0] amplitude_q8;
  } det_t;

  // Verdict of one finished frame, handed from the frame checker to the output queue.
  typedef struct packed {
    status_e     status;
    logic [7:0]  detection_count;
    logic [31:0] timestamp;
    logic [1:0]  last_index;
  } report_t;

  // One byte of CRC-16/MODBUS, reflected, bit by bit.
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/mdfp_in_if.sv
interface mdfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;

  modport source (output valid, rx_byte, frame_end, input ready);
  modport sink (input valid, rx_byte, frame_end, output ready);
endinterface

>>> rtl/mdfp_res_if.sv
interface mdfp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  detection_count;
  logic [31:0] timestamp;
  logic        has_detection;
  logic [1:0]  detection_index;
  logic [15:0] distance_cm;
  logic [15:0] amplitude_q8;
  logic        last;

  modport source (
    output valid, status, detection_count, timestamp, has_detection,
           detection_index, distance_cm, amplitude_q8, last,
    input  ready
  );
  modport sink (
    input  valid, status, detection_count, timestamp, has_detection,
           detection_index, distance_cm, amplitude_q8, last,
    output ready
  );
endinterface

>>> rtl/mdfp_cfg_if.sv
interface mdfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] device_address;

  modport source (output valid, device_address, input ready);
  modport sink (input valid, device_address, output ready);
endinterface

>>> rtl/modbus_detection_frame_parser_top.sv
// Channel   Dir  Payload                                          Accepted when
// cfg_i     in   device_address                                   valid & ready (ready is 1)
// in_i      in   rx_byte, frame_end                               valid & ready
// res_o     out  status, detection_count, timestamp,              valid & ready
//                has_detection, detection_index, distance_cm,
//                amplitude_q8, last
//
// One received byte is taken per cycle while the input is ready; its store write ends in
// that cycle. A frame end yields a report registered into the head (or the skid), which
// gives 1 to MaxDetections results, one per cycle while the output is ready, from the head.
// A second finished report waits in a skid register; the input stalls only while it is full.
// Reset clears the byte counter and the report queue, sets the CRC to FFFF and the address to 1.
module modbus_detection_frame_parser_top #(
  parameter int unsigned MaxDetections = mdfp_pkg::MAX_DET_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mdfp_cfg_if.sink   cfg_i,
  mdfp_in_if.sink    in_i,
  mdfp_res_if.source res_o
);

  logic              accept;
  logic              done;
  logic [7:0]        dev_addr_q;
  mdfp_pkg::report_t new_report;
  mdfp_pkg::det_t    new_dets [MaxDetections];

  logic              head_valid_q, head_valid_d;
  mdfp_pkg::report_t head_q;
  mdfp_pkg::det_t    head_dets_q [MaxDetections];
  logic [1:0]        idx_q, idx_d;
  logic              skid_valid_q, skid_valid_d;
  mdfp_pkg::report_t skid_q;
  mdfp_pkg::det_t    skid_dets_q [MaxDetections];

  logic              head_take, head_final, head_free;
  logic              load_from_skid, load_from_new, load_skid;
  logic              has_det;
  mdfp_pkg::det_t    sel_det;

  // Configuration register.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= mdfp_pkg::DEV_ADDR_RESET;
    end else if (cfg_i.valid) begin
      dev_addr_q <= cfg_i.device_address;
    end
  end

  // Byte intake and frame checks.
  assign in_i.ready = !skid_valid_q;
  assign accept     = in_i.valid && in_i.ready;

  mdfp_frame_check #(
    .MaxDetections (MaxDetections)
  ) u_frame_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .rx_byte_i   (in_i.rx_byte),
    .frame_end_i (in_i.frame_end),
    .dev_addr_i  (dev_addr_q),
    .done_o      (done),
    .report_o    (new_report),
    .dets_o      (new_dets)
  );

  // Two-entry report queue: the head feeds the output, the skid catches a second frame end.
  assign head_take  = head_valid_q && res_o.ready;
  assign head_final = (idx_q == head_q.last_index);
  assign head_free  = !head_valid_q || (head_take && head_final);

  assign load_from_skid = head_free && skid_valid_q;
  assign load_from_new  = head_free && !skid_valid_q && done;
  assign load_skid      = done && !head_free;

  always_comb begin
    head_valid_d = head_free ? (skid_valid_q || done) : 1'b1;
    skid_valid_d = load_skid ? 1'b1 : (load_from_skid ? 1'b0 : skid_valid_q);
    idx_d        = idx_q;
    if (head_free) begin
      idx_d = 2'd0;
    end else if (head_take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
      idx_q        <= 2'd0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_from_skid) begin
      head_q      <= skid_q;
      head_dets_q <= skid_dets_q;
    end else if (load_from_new) begin
      head_q      <= new_report;
      head_dets_q <= new_dets;
    end
    if (load_skid) begin
      skid_q      <= new_report;
      skid_dets_q <= new_dets;
    end
  end

  // Result fields of the current detection slot.
  assign has_det = (head_q.status == mdfp_pkg::STATUS_OK) &&
                   ({6'd0, idx_q} < head_q.detection_count);

  always_comb begin
    sel_det = '0;
    for (int k = 0; k < MaxDetections; k++) begin
      if (idx_q == 2'(k)) begin
        sel_det = head_dets_q[k];
      end
    end
    if (!has_det) begin
      sel_det = '0;
    end
  end

  assign res_o.valid           = head_valid_q;
  assign res_o.status          = head_q.status;
  assign res_o.detection_count = head_q.detection_count;
  assign res_o.timestamp       = head_q.timestamp;
  assign res_o.has_detection   = has_det;
  assign res_o.detection_index = has_det ? idx_q : 2'd0;
  assign res_o.distance_cm     = sel_det.distance_cm;
  assign res_o.amplitude_q8    = sel_det.amplitude_q8;
  assign res_o.last            = head_final;

endmodule

>>> rtl/mdfp_frame_check.sv
module mdfp_frame_check #(
  parameter int unsigned MaxDetections = mdfp_pkg::MAX_DET_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                frame_end_i,
  input  logic [7:0]          dev_addr_i,
  output logic                done_o,
  output mdfp_pkg::report_t   report_o,
  output mdfp_pkg::det_t      dets_o [MaxDetections]
);

  logic [mdfp_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]                crc_q, crc_d;
  logic [15:0]                crc_step;
  logic                       crc_adv;
  logic [7:0]                 store_q [mdfp_pkg::FRAME_LEN];
  logic [7:0]                 prev1_q, prev2_q;
  logic                       len_ok, hdr_ok, crc_ok, too_many;
  logic [7:0]                 det_count;

  // The CRC trails the input by two bytes, so the byte two requests back feeds it.
  assign crc_step = mdfp_pkg::crc16_byte(crc_q, prev2_q);
  assign crc_adv  = (cnt_q >= mdfp_pkg::CNT_CRC_START) && (cnt_q < mdfp_pkg::CNT_FRAME_LEN);

  // Counter and CRC update; a frame end returns both to their reset values.
  always_comb begin
    cnt_d = cnt_q;
    crc_d = crc_q;
    if (accept_i) begin
      if (frame_end_i) begin
        cnt_d = '0;
        crc_d = mdfp_pkg::CRC_INIT;
      end else begin
        if (cnt_q < mdfp_pkg::CNT_SAT) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (crc_adv) begin
          crc_d = crc_step;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      crc_q <= mdfp_pkg::CRC_INIT;
    end else begin
      cnt_q <= cnt_d;
      crc_q <= crc_d;
    end
  end

  // Frame bytes and the two-byte delay line; bytes past a full frame are dropped.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      if (cnt_q < mdfp_pkg::CNT_FRAME_LEN) begin
        store_q[cnt_q] <= rx_byte_i;
      end
      prev1_q <= rx_byte_i;
      prev2_q <= prev1_q;
    end
  end

  // Checks at the final byte; the final byte itself is the high CRC byte.
  assign det_count = store_q[mdfp_pkg::COUNT_OFFSET];
  assign len_ok    = (cnt_q == mdfp_pkg::CNT_LAST_BYTE);
  assign hdr_ok    = (store_q[0] == dev_addr_i) && (store_q[1] == mdfp_pkg::FUNC_READ_INPUT);
  assign crc_ok    = (store_q[mdfp_pkg::CRC_LO_POS] == crc_step[7:0]) &&
                     (rx_byte_i == crc_step[15:8]);
  assign too_many  = (det_count > 8'(MaxDetections));
  assign done_o    = accept_i && frame_end_i;

  always_comb begin
    report_o = '0;
    priority if (!len_ok || !hdr_ok) begin
      report_o.status = mdfp_pkg::STATUS_BAD_RESP;
    end else if (!crc_ok) begin
      report_o.status = mdfp_pkg::STATUS_BAD_CRC;
    end else if (too_many) begin
      report_o.status          = mdfp_pkg::STATUS_TOO_MANY;
      report_o.detection_count = det_count;
    end else begin
      report_o.status          = mdfp_pkg::STATUS_OK;
      report_o.detection_count = det_count;
      report_o.timestamp       = {store_q[5], store_q[6], store_q[3], store_q[4]};
      report_o.last_index      = (det_count == 8'd0) ? 2'd0 : det_count[1:0] - 2'd1;
    end
  end

  // Detection fields at their fixed frame offsets.
  always_comb begin
    for (int k = 0; k < MaxDetections; k++) begin
      dets_o[k].distance_cm  = {store_q[mdfp_pkg::DET_OFFSET + mdfp_pkg::DET_BYTES*k],
                                store_q[mdfp_pkg::DET_OFFSET + mdfp_pkg::DET_BYTES*k + 1]};
      dets_o[k].amplitude_q8 = {store_q[mdfp_pkg::DET_OFFSET + mdfp_pkg::DET_BYTES*k + 2],
                                store_q[mdfp_pkg::DET_OFFSET + mdfp_pkg::DET_BYTES*k + 3]};
    end
  end

endmodule

>>> rtl/mdfp_checker.sv
`include "modbus_detection_frame_parser_top_assert.svh"

module mdfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [1:0]  status_i,
  input logic [7:0]  detection_count_i,
  input logic        has_detection_i,
  input logic [1:0]  detection_index_i,
  input logic        last_i
);

  // A stalled result keeps its position in the frame.
  `MDFP_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(detection_index_i) && $stable(last_i), "stalled result changed")

  // A failed frame gives a single result without a detection.
  `MDFP_ASSERT_NOW(a_fail_single, clk_i, rst_ni, res_valid_i && (status_i != mdfp_pkg::STATUS_OK), last_i && !has_detection_i, "failed frame result is not a lone final one")

  // A carried detection lies inside the reported count.
  `MDFP_ASSERT_NOW(a_det_in_range, clk_i, rst_ni, res_valid_i && has_detection_i, {6'd0, detection_index_i} < detection_count_i, "detection index beyond count")

  // A taken result that is not the last is followed by the next detection of the same frame.
  `MDFP_ASSERT_NEXT(a_det_follow, clk_i, rst_ni, res_valid_i && res_ready_i && !last_i, res_valid_i && has_detection_i && (detection_index_i == $past(detection_index_i) + 2'd1), "frame results broken off")

endmodule

bind modbus_detection_frame_parser_top mdfp_checker u_mdfp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .status_i          (res_o.status),
  .detection_count_i (res_o.detection_count),
  .has_detection_i   (res_o.has_detection),
  .detection_index_i (res_o.detection_index),
  .last_i            (res_o.last)
);
